// File: src/protobuf_piece_list_parser_unit_assert.svh
// Assertion macros for the piece list parser.
// Used by protobuf_piece_list_parser_unit; expects clk and rst_n in scope.
`ifndef PROTOBUF_PIECE_LIST_PARSER_UNIT_ASSERT_SVH
`define PROTOBUF_PIECE_LIST_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define PBPL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pbpl_pkg.sv
// Shared types and codes for the piece list parser.
// No dependencies.
package pbpl_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } pbpl_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [18:0] piece_index;
    logic [7:0]  byte_value;
    logic [11:0] byte_offset;
    logic [31:0] score_bits;
    logic [12:0] piece_length;
    logic [2:0]  error_code;
    logic        last;
  } pbpl_out_t;

  // up to three results per byte, handed to the result queue
  typedef struct packed {
    logic [1:0]            cnt;
    pbpl_out_t [2:0]       item;
  } pbpl_push_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [2:0] ERR_TRUNC   = 3'd0;
  localparam logic [2:0] ERR_VARINT  = 3'd1;
  localparam logic [2:0] ERR_WIRE    = 3'd2;
  localparam logic [2:0] ERR_STRLEN  = 3'd3;
  localparam logic [2:0] ERR_COUNT   = 3'd4;

  localparam logic [3:0] PH_OTAG   = 4'd0;
  localparam logic [3:0] PH_OVAL   = 4'd1;
  localparam logic [3:0] PH_OSKIP  = 4'd2;
  localparam logic [3:0] PH_OLEN   = 4'd3;
  localparam logic [3:0] PH_ITAG   = 4'd4;
  localparam logic [3:0] PH_IVAL   = 4'd5;
  localparam logic [3:0] PH_ILEN   = 4'd6;
  localparam logic [3:0] PH_ISTR   = 4'd7;
  localparam logic [3:0] PH_ISCORE = 4'd8;
  localparam logic [3:0] PH_ISKIP  = 4'd9;
  localparam logic [3:0] PH_ERR    = 4'd10;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam logic [3:0] QUEUE_DEPTH = 4'd8;

endpackage

// File: src/pbpl_parser.sv
// Parser state and per-byte decode logic; produces up to three results per byte.
// Depends on pbpl_pkg.
module pbpl_parser import pbpl_pkg::*; #(
  parameter int MAX_PIECES     = 524288,
  parameter int MAX_STRING_LEN = 4096,
  parameter int LEN_BITS       = 27
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  pbpl_in_t   item,
  output pbpl_push_t push
);

  localparam int PC_W = $clog2(MAX_PIECES + 1);
  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_BITS) - 64'd1);

  logic [3:0]          phase_r, phase_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic                acc_hi_r, acc_hi_nxt;
  logic [3:0]          vb_r, vb_nxt;
  logic [LEN_BITS-1:0] orem_r, orem_nxt;
  logic [12:0]         irem_r, irem_nxt;
  logic [LEN_BITS-1:0] skip_r, skip_nxt;
  logic [1:0]          field_r, field_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [31:0]         score_r, score_nxt;
  logic [12:0]         slen_r, slen_nxt;
  logic                err_r, err_nxt;

  function automatic pbpl_out_t mk_res(logic [1:0] kind, logic [18:0] idx,
                                       logic [7:0] bv, logic [11:0] off,
                                       logic [31:0] sc, logic [12:0] len,
                                       logic [2:0] code);
    pbpl_out_t r;
    r.kind         = kind;
    r.piece_index  = idx;
    r.byte_value   = bv;
    r.byte_offset  = off;
    r.score_bits   = sc;
    r.piece_length = len;
    r.error_code   = code;
    r.last         = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0]          b;
    logic [5:0]          shamt;
    logic [63:0]         sh;
    logic [31:0]         v_lo;
    logic                v_hi;
    logic                vlong;
    logic                vdone;
    logic                failed;
    logic                is_f1;
    logic                is_f2;
    logic [LEN_BITS-1:0] od;
    logic [1:0]          n;
    logic [1:0]          sel;

    b      = item.data_byte;
    shamt  = 6'({2'b00, vb_r} * 6'd7);
    sh     = 64'(b[6:0]) << shamt;
    v_lo   = acc_r | sh[31:0];
    v_hi   = acc_hi_r | (sh[63:32] != 32'd0);
    vlong  = (vb_r >= VARINT_MAX_BYTES);
    vdone  = !b[7];
    is_f1  = !v_hi && (v_lo[31:3] == 29'd1);
    is_f2  = !v_hi && (v_lo[31:3] == 29'd2);
    od     = orem_r - LEN_BITS'(1);
    failed = 1'b0;
    n      = 2'd0;
    sel    = 2'd0 - skip_r[1:0];

    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    acc_hi_nxt = acc_hi_r;
    vb_nxt     = vb_r;
    orem_nxt   = orem_r;
    irem_nxt   = irem_r;
    skip_nxt   = skip_r;
    field_nxt  = field_r;
    pc_nxt     = pc_r;
    score_nxt  = score_r;
    slen_nxt   = slen_r;
    err_nxt    = err_r;
    push       = '0;

    if (go) begin
      if (!err_r) begin
        // shared varint step for all varint phases
        if (phase_r == PH_OTAG || phase_r == PH_OVAL || phase_r == PH_OLEN ||
            phase_r == PH_ITAG || phase_r == PH_IVAL || phase_r == PH_ILEN) begin
          if (vlong) begin
            failed = 1'b1;
            push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_VARINT);
            n = n + 2'd1;
          end else if (vdone) begin
            acc_nxt = '0; acc_hi_nxt = 1'b0; vb_nxt = '0;
          end else begin
            acc_nxt = v_lo; acc_hi_nxt = v_hi; vb_nxt = vb_r + 4'd1;
          end
        end
        if (phase_r >= PH_ITAG && phase_r <= PH_ISKIP) orem_nxt = od;

        if (!failed) begin
          case (phase_r)
            PH_OTAG: if (vdone) begin
              field_nxt = is_f1 ? 2'd1 : 2'd0;
              case (v_lo[2:0])
                WT_VARINT: phase_nxt = PH_OVAL;
                WT_FIX64: begin skip_nxt = LEN_BITS'(8); phase_nxt = PH_OSKIP; end
                WT_FIX32: begin skip_nxt = LEN_BITS'(4); phase_nxt = PH_OSKIP; end
                WT_LEN:   phase_nxt = PH_OLEN;
                default:  begin
                  failed = 1'b1;
                  push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_WIRE);
                  n = n + 2'd1;
                end
              endcase
            end
            PH_OVAL: if (vdone) phase_nxt = PH_OTAG;
            PH_OSKIP: begin
              skip_nxt = skip_r - LEN_BITS'(1);
              if (skip_r == LEN_BITS'(1)) phase_nxt = PH_OTAG;
            end
            PH_OLEN: if (vdone) begin
              if (v_hi || ((v_lo & ~LEN_MASK) != 32'd0)) begin
                failed = 1'b1;
                push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_TRUNC);
                n = n + 2'd1;
              end else if (field_r == 2'd1) begin
                if (32'(pc_r) >= 32'(MAX_PIECES)) begin
                  failed = 1'b1;
                  push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_COUNT);
                  n = n + 2'd1;
                end else begin
                  score_nxt = '0;
                  slen_nxt  = '0;
                  orem_nxt  = v_lo[LEN_BITS-1:0];
                  if (v_lo == 32'd0) begin
                    // empty piece ends right at its length byte
                    push.item[n] = mk_res(KIND_END, 19'(pc_r), '0, '0, '0, '0, ERR_TRUNC);
                    n = n + 2'd1;
                    pc_nxt = pc_r + PC_W'(1);
                    phase_nxt = PH_OTAG;
                  end else begin
                    phase_nxt = PH_ITAG;
                  end
                end
              end else if (v_lo == 32'd0) begin
                phase_nxt = PH_OTAG;
              end else begin
                skip_nxt  = v_lo[LEN_BITS-1:0];
                phase_nxt = PH_OSKIP;
              end
            end
            PH_ITAG: if (vdone) begin
              field_nxt = is_f1 ? 2'd1 : (is_f2 ? 2'd2 : 2'd0);
              case (v_lo[2:0])
                WT_VARINT: phase_nxt = PH_IVAL;
                WT_FIX64: begin
                  if (od < LEN_BITS'(8)) begin
                    failed = 1'b1;
                    push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_TRUNC);
                    n = n + 2'd1;
                  end else begin
                    skip_nxt = LEN_BITS'(8); phase_nxt = PH_ISKIP;
                  end
                end
                WT_FIX32: begin
                  if (od < LEN_BITS'(4)) begin
                    failed = 1'b1;
                    push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_TRUNC);
                    n = n + 2'd1;
                  end else begin
                    skip_nxt  = LEN_BITS'(4);
                    phase_nxt = is_f2 ? PH_ISCORE : PH_ISKIP;
                  end
                end
                WT_LEN: phase_nxt = PH_ILEN;
                default: begin
                  failed = 1'b1;
                  push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_WIRE);
                  n = n + 2'd1;
                end
              endcase
            end
            PH_IVAL: if (vdone) phase_nxt = PH_ITAG;
            PH_ILEN: if (vdone) begin
              if (v_hi || (v_lo > 32'(od))) begin
                failed = 1'b1;
                push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_TRUNC);
                n = n + 2'd1;
              end else if (field_r == 2'd1) begin
                if (v_lo > 32'(MAX_STRING_LEN)) begin
                  failed = 1'b1;
                  push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_STRLEN);
                  n = n + 2'd1;
                end else begin
                  slen_nxt  = v_lo[12:0];
                  irem_nxt  = v_lo[12:0];
                  phase_nxt = (v_lo == 32'd0) ? PH_ITAG : PH_ISTR;
                end
              end else if (v_lo == 32'd0) begin
                phase_nxt = PH_ITAG;
              end else begin
                skip_nxt  = v_lo[LEN_BITS-1:0];
                phase_nxt = PH_ISKIP;
              end
            end
            PH_ISTR: begin
              push.item[n] = mk_res(KIND_BYTE, 19'(pc_r), b, 12'(slen_r - irem_r),
                                    '0, slen_r, ERR_TRUNC);
              n = n + 2'd1;
              irem_nxt = irem_r - 13'd1;
              if (irem_r == 13'd1) phase_nxt = PH_ITAG;
            end
            PH_ISCORE: begin
              case (sel)
                2'd0:    score_nxt[7:0]   = b;
                2'd1:    score_nxt[15:8]  = b;
                2'd2:    score_nxt[23:16] = b;
                default: score_nxt[31:24] = b;
              endcase
              skip_nxt = skip_r - LEN_BITS'(1);
              if (skip_r == LEN_BITS'(1)) phase_nxt = PH_ITAG;
            end
            PH_ISKIP: begin
              skip_nxt = skip_r - LEN_BITS'(1);
              if (skip_r == LEN_BITS'(1)) phase_nxt = PH_ITAG;
            end
            default: ;
          endcase
        end

        // piece boundary check after each byte inside a piece
        if (!failed && phase_r >= PH_ITAG && phase_r <= PH_ISKIP &&
            od == LEN_BITS'(0)) begin
          if (phase_nxt == PH_ITAG && vb_nxt == 4'd0) begin
            push.item[n] = mk_res(KIND_END, 19'(pc_r), '0, '0, score_nxt, slen_nxt,
                                  ERR_TRUNC);
            n = n + 2'd1;
            pc_nxt = pc_r + PC_W'(1);
            phase_nxt = PH_OTAG;
          end else begin
            failed = 1'b1;
            push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_TRUNC);
            n = n + 2'd1;
          end
        end

        if (failed) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_ERR;
        end
      end

      if (item.end_of_file) begin
        if (!err_nxt) begin
          if (phase_nxt == PH_OTAG && vb_nxt == 4'd0) begin
            if (pc_nxt != PC_W'(0)) begin
              push.item[n] = mk_res(KIND_OK, '0, '0, '0, '0, '0, ERR_TRUNC);
            end else begin
              push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_COUNT);
            end
          end else begin
            push.item[n] = mk_res(KIND_ERR, '0, '0, '0, '0, '0, ERR_TRUNC);
          end
          n = n + 2'd1;
        end
        phase_nxt  = PH_OTAG;
        acc_nxt    = '0;
        acc_hi_nxt = 1'b0;
        vb_nxt     = '0;
        orem_nxt   = '0;
        irem_nxt   = '0;
        skip_nxt   = '0;
        field_nxt  = '0;
        pc_nxt     = '0;
        score_nxt  = '0;
        slen_nxt   = '0;
        err_nxt    = 1'b0;
      end

      if (n != 2'd0) push.item[n - 2'd1].last = 1'b1;
      push.cnt = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OTAG;
      acc_r    <= '0;
      acc_hi_r <= 1'b0;
      vb_r     <= '0;
      orem_r   <= '0;
      irem_r   <= '0;
      skip_r   <= '0;
      field_r  <= '0;
      pc_r     <= '0;
      score_r  <= '0;
      slen_r   <= '0;
      err_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      acc_hi_r <= acc_hi_nxt;
      vb_r     <= vb_nxt;
      orem_r   <= orem_nxt;
      irem_r   <= irem_nxt;
      skip_r   <= skip_nxt;
      field_r  <= field_nxt;
      pc_r     <= pc_nxt;
      score_r  <= score_nxt;
      slen_r   <= slen_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// File: src/pbpl_queue.sv
// Eight-entry result queue; takes up to three results per cycle, gives one.
// Depends on pbpl_pkg.
module pbpl_queue import pbpl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pbpl_push_t push,
  input  logic       pop,
  output logic [3:0] count,
  output pbpl_out_t  head
);

  pbpl_out_t  mem [8];
  logic [2:0] wr_r, wr_nxt;
  logic [2:0] rd_r, rd_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r + 3'(push.cnt);
    rd_nxt  = rd_r + 3'(pop);
    cnt_nxt = cnt_r + 4'(push.cnt) - 4'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt > 2'd0) mem[wr_r]        <= push.item[0];
    if (push.cnt > 2'd1) mem[wr_r + 3'd1] <= push.item[1];
    if (push.cnt > 2'd2) mem[wr_r + 3'd2] <= push.item[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign count = cnt_r;
  assign head  = mem[rd_r];

endmodule

// File: src/protobuf_piece_list_parser_unit.sv
// Piece list parser, top level: input register, parser, result queue.
// Depends on pbpl_pkg, pbpl_parser, pbpl_queue and the assertion macro header.
//
// Usage: one model-file byte per input transfer (in_valid/in_stall, payload
// in_data), end_of_file set on the file's last byte. Results leave on
// out_valid/out_stall as out_data: string bytes, piece ends, and one verdict
// (load ok or load error) per file. After an error the rest of the file
// gives no results; the file end returns the parser to its start state.
// Timing: a byte sits in the input register from its transfer edge and is
// decoded once the queue has room; its results are registered in the queue.
// Throughput: one byte per cycle while the eight-entry result queue has room
// for three results; a byte may give up to three results, and the output
// side drains one per cycle, so bursts that give several results per byte
// stall the input. A stalled receiver fills the queue, then in_stall rises.
// Reset: synchronous, active low; clears the parser state and the queue.
`include "protobuf_piece_list_parser_unit_assert.svh"
module protobuf_piece_list_parser_unit import pbpl_pkg::*; #(
  parameter int MAX_PIECES     = 524288,
  parameter int MAX_STRING_LEN = 4096,
  parameter int LEN_BITS       = 27
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pbpl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pbpl_out_t out_data
);

  pbpl_in_t   in_r;
  logic       in_vld_r, in_vld_nxt;
  logic       go;
  logic [3:0] q_count;
  pbpl_push_t push;

  // decode the held byte once the queue can take its worst case
  assign go       = in_vld_r && (q_count <= QUEUE_DEPTH - 4'd3);
  assign in_stall = in_vld_r && !go;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) in_vld_nxt = 1'b1;
    else if (go)               in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= in_vld_nxt;
  end

  pbpl_parser #(
    .MAX_PIECES    (MAX_PIECES),
    .MAX_STRING_LEN(MAX_STRING_LEN),
    .LEN_BITS      (LEN_BITS)
  ) u_parser (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .item (in_r),
    .push (push)
  );

  pbpl_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (out_valid && !out_stall),
    .count(q_count),
    .head (out_data)
  );

  assign out_valid = (q_count != 4'd0);

  `PBPL_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QUEUE_DEPTH, "result queue overflow")
  `PBPL_ASSERT_NOW(a_push_only_on_go, push.cnt != 2'd0, go, "results without a decoded byte")
  `PBPL_ASSERT_NOW(a_err_code, out_valid && out_data.kind == KIND_ERR,
                   out_data.error_code <= ERR_COUNT, "bad error code")
  `PBPL_ASSERT_NEXT(a_go_drains, go && !(in_valid && !in_stall), !in_vld_r,
                    "decoded byte not released")

endmodule

// File: test/protobuf_piece_list_parser_unit_test.sv
// Testbench for protobuf_piece_list_parser_unit: streams model files byte by byte
// and checks each result against a behavioral parser model kept in a scoreboard.
// Depends on pbpl_pkg and the block under test.
module protobuf_piece_list_parser_unit_test;
  import pbpl_pkg::*;

  localparam int MAX_PCS = 524288;
  localparam int MAX_STR = 4096;
  localparam int LENB = 27;
  localparam int WATCHDOG = 20000;

  class piece_scoreboard;
    logic [3:0] phase;
    logic [63:0] acc;
    int unsigned vbytes;
    longint unsigned outer_rem, inner_rem, skip_rem;
    int unsigned field;
    int unsigned count;
    logic [31:0] score;
    int unsigned slen;
    bit err;
    pbpl_out_t pending[$];
    pbpl_out_t step_res[$];
    int failures;

    function void clear_state();
      phase = PH_OTAG; acc = 0; vbytes = 0; outer_rem = 0; inner_rem = 0;
      skip_rem = 0; field = 0; count = 0; score = 0; slen = 0; err = 0;
    endfunction

    function void push(logic [1:0] k, int unsigned idx, logic [7:0] bv, int unsigned off,
                       logic [31:0] sc, int unsigned len, logic [2:0] code);
      pbpl_out_t r;
      if (step_res.size() >= 3) return;
      r.kind = k; r.piece_index = idx[18:0]; r.byte_value = bv; r.byte_offset = off[11:0];
      r.score_bits = sc; r.piece_length = len[12:0]; r.error_code = code; r.last = 0;
      step_res.push_back(r);
    endfunction

    function void raise_err(logic [2:0] code);
      push(KIND_ERR, 0, 0, 0, 0, 0, code);
      err = 1; phase = PH_ERR;
    endfunction

    // -1 too long, 0 more bytes, 1 done
    function int varint_byte(logic [7:0] b);
      if (vbytes >= 10) return -1;
      acc |= 64'(b[6:0]) << (7 * vbytes);
      vbytes++;
      return b[7] ? 0 : 1;
    endfunction

    function void finish_piece();
      push(KIND_END, count, 0, 0, score, slen, 0);
      count++;
      phase = PH_OTAG;
    endfunction

    function void outer_step(logic [7:0] b);
      int r;
      logic [63:0] v;
      r = varint_byte(b);
      if (phase == PH_OSKIP) begin
        // skip bytes are not varints; undo
        acc = 0; vbytes = 0;
        skip_rem--;
        if (skip_rem == 0) phase = PH_OTAG;
        return;
      end
      if (r < 0) begin raise_err(ERR_VARINT); return; end
      if (r == 0) return;
      v = acc; acc = 0; vbytes = 0;
      case (phase)
        PH_OTAG: begin
          field = (v >> 3) == 1 ? 1 : 0;
          case (v[2:0])
            WT_VARINT: phase = PH_OVAL;
            WT_FIX64: begin skip_rem = 8; phase = PH_OSKIP; end
            WT_FIX32: begin skip_rem = 4; phase = PH_OSKIP; end
            WT_LEN: phase = PH_OLEN;
            default: raise_err(ERR_WIRE);
          endcase
        end
        PH_OVAL: phase = PH_OTAG;
        default: begin
          if (v > (64'd1 << LENB) - 1) begin raise_err(ERR_TRUNC); return; end
          if (field == 1) begin
            if (count >= MAX_PCS) begin raise_err(ERR_COUNT); return; end
            score = 0; slen = 0; outer_rem = v;
            if (v == 0) finish_piece(); else phase = PH_ITAG;
          end else if (v == 0) phase = PH_OTAG;
          else begin skip_rem = v; phase = PH_OSKIP; end
        end
      endcase
    endfunction

    function void inner_step(logic [7:0] b);
      int r;
      logic [63:0] v;
      int pos;
      outer_rem--;
      case (phase)
        PH_ITAG, PH_IVAL, PH_ILEN: begin
          r = varint_byte(b);
          if (r < 0) begin raise_err(ERR_VARINT); return; end
          if (r > 0) begin
            v = acc; acc = 0; vbytes = 0;
            if (phase == PH_IVAL) phase = PH_ITAG;
            else if (phase == PH_ITAG) begin
              field = (v >> 3) == 1 ? 1 : ((v >> 3) == 2 ? 2 : 0);
              case (v[2:0])
                WT_VARINT: phase = PH_IVAL;
                WT_FIX64: begin
                  if (outer_rem < 8) begin raise_err(ERR_TRUNC); return; end
                  skip_rem = 8; phase = PH_ISKIP;
                end
                WT_FIX32: begin
                  if (outer_rem < 4) begin raise_err(ERR_TRUNC); return; end
                  skip_rem = 4; phase = field == 2 ? PH_ISCORE : PH_ISKIP;
                end
                WT_LEN: phase = PH_ILEN;
                default: begin raise_err(ERR_WIRE); return; end
              endcase
            end else begin
              if (v > outer_rem) begin raise_err(ERR_TRUNC); return; end
              if (field == 1) begin
                if (v > MAX_STR) begin raise_err(ERR_STRLEN); return; end
                slen = v; inner_rem = v;
                phase = v == 0 ? PH_ITAG : PH_ISTR;
              end else if (v == 0) phase = PH_ITAG;
              else begin skip_rem = v; phase = PH_ISKIP; end
            end
          end
        end
        PH_ISTR: begin
          push(KIND_BYTE, count, b, slen - inner_rem, 0, slen, 0);
          inner_rem--;
          if (inner_rem == 0) phase = PH_ITAG;
        end
        PH_ISCORE: begin
          pos = 8 * ((4 - skip_rem) & 3);
          score[pos +: 8] = b;
          skip_rem--;
          if (skip_rem == 0) phase = PH_ITAG;
        end
        default: begin
          skip_rem--;
          if (skip_rem == 0) phase = PH_ITAG;
        end
      endcase
      if (outer_rem == 0) begin
        if (phase == PH_ITAG && vbytes == 0) finish_piece();
        else raise_err(ERR_TRUNC);
      end
    endfunction

    function void note_input(pbpl_in_t d);
      step_res.delete();
      if (!err) begin
        if (phase <= PH_OLEN) outer_step(d.data_byte);
        else if (phase < PH_ERR) inner_step(d.data_byte);
      end
      if (d.end_of_file) begin
        if (!err) begin
          if (phase == PH_OTAG && vbytes == 0) begin
            if (count >= 1) push(KIND_OK, 0, 0, 0, 0, 0, 0);
            else raise_err(ERR_COUNT);
          end else raise_err(ERR_TRUNC);
        end
        clear_state();
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1;
      foreach (step_res[i]) pending.push_back(step_res[i]);
    endfunction

    function void check_result(pbpl_out_t got);
      pbpl_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d", got.kind);
        failures++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d got %0d", e.kind, got.kind); failures++; end
      if (got.piece_index !== e.piece_index) begin
        $error("piece_index: expected %0d got %0d", e.piece_index, got.piece_index);
        failures++; end
      if (got.byte_value !== e.byte_value) begin
        $error("byte_value: expected %0h got %0h", e.byte_value, got.byte_value);
        failures++; end
      if (got.byte_offset !== e.byte_offset) begin
        $error("byte_offset: expected %0d got %0d", e.byte_offset, got.byte_offset);
        failures++; end
      if (got.score_bits !== e.score_bits) begin
        $error("score_bits: expected %0h got %0h", e.score_bits, got.score_bits);
        failures++; end
      if (got.piece_length !== e.piece_length) begin
        $error("piece_length: expected %0d got %0d", e.piece_length, got.piece_length);
        failures++; end
      if (got.error_code !== e.error_code) begin
        $error("error_code: expected %0d got %0d", e.error_code, got.error_code);
        failures++; end
      if (got.last !== e.last) begin
        $error("last: expected %0d got %0d", e.last, got.last); failures++; end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  pbpl_in_t in_data;
  pbpl_out_t out_data;

  protobuf_piece_list_parser_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  piece_scoreboard board;
  bit idle_in_on, idle_out_on, hold_out, done;
  int quiet_cycles;
  byte unsigned file_bytes[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // one transfer per call, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic eof);
    while (idle_in_on && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{data_byte: b, end_of_file: eof};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input('{data_byte: b, end_of_file: eof});
  endtask

  // in_valid stays up after the last transfer; the next file or a drain wait drives it
  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  task automatic put_varint(longint unsigned v);
    do begin
      file_bytes.push_back(v[6:0] | (v > 127 ? 8'h80 : 8'h00));
      v = v >> 7;
    end while (v != 0);
  endtask

  // piece with a string of slen random bytes and optional score / extra record
  task automatic put_piece(int slen, bit with_score, bit with_extra);
    byte unsigned body[$];
    byte unsigned saved[$];
    saved = file_bytes;
    file_bytes.delete();
    if (with_extra) begin put_varint((3 << 3) | WT_VARINT); put_varint($urandom); end
    put_varint((1 << 3) | WT_LEN); put_varint(slen);
    repeat (slen) file_bytes.push_back($urandom_range(255));
    if (with_score) begin
      put_varint((2 << 3) | WT_FIX32);
      repeat (4) file_bytes.push_back($urandom_range(255));
    end
    body = file_bytes;
    file_bytes = saved;
    put_varint((1 << 3) | WT_LEN);
    put_varint(body.size());
    foreach (body[i]) file_bytes.push_back(body[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // receiver
  initial begin
    out_stall = 1;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_result(out_data);
      out_stall <= hold_out || (idle_out_on && $urandom_range(99) < 36);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && !done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int n;
    board = new();
    board.clear_state();
    board.failures = 0;
    in_valid = 0; in_data = '0; rst_n = 0; quiet_cycles = 0;
    idle_in_on = 0; idle_out_on = 0; hold_out = 0; done = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: good file with extremes, every wire type at top level
    put_varint((2 << 3) | WT_VARINT); put_varint(64'hffff_ffff_ffff_ffff);
    put_varint((3 << 3) | WT_FIX64); repeat (8) file_bytes.push_back(8'hff);
    put_varint((4 << 3) | WT_FIX32); repeat (4) file_bytes.push_back(8'h00);
    put_varint((5 << 3) | WT_LEN); put_varint(0);
    put_piece(0, 0, 0);
    file_bytes.push_back(8'h0a); file_bytes.push_back(8'h00); // empty piece
    put_piece(2, 1, 1);
    send_file();
    // file without pieces: count error
    file_bytes.push_back(8'h08); file_bytes.push_back(8'h00); send_file();
    // bad wire type, varint too long, truncated, string too long
    file_bytes.push_back(8'h0b); file_bytes.push_back(8'h55); send_file();
    repeat (11) file_bytes.push_back(8'hff); file_bytes.push_back(8'h01); send_file();
    put_piece(1, 0, 0); void'(file_bytes.pop_back()); send_file();
    file_bytes.push_back(8'h0a); put_varint(4100);
    file_bytes.push_back(8'h0a); file_bytes.push_back(8'h81); file_bytes.push_back(8'h20);
    file_bytes.push_back(8'h00); send_file();
    // huge outer length
    file_bytes.push_back(8'h0a); put_varint(64'd1 << LENB); send_file();
    wait_drained();

    // fill the queue under a long receiver hold-off
    fork
      begin hold_out = 1; repeat (200) @(posedge clk); hold_out = 0; end
    join_none
    put_piece(20, 1, 0); send_file();
    wait_drained();

    idle_in_on = 1; idle_out_on = 1;
    n = 0;
    while (n < 400) begin
      if (n > 150 && n < 230) begin idle_in_on = 0; idle_out_on = 0; end
      else begin idle_in_on = 1; idle_out_on = 1; end
      if ($urandom_range(9) < 8) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(3) == 0) begin
            put_varint(($urandom_range(2, 9) << 3) | WT_VARINT); put_varint($urandom);
          end
          put_piece($urandom_range(0, 6), $urandom_range(1), $urandom_range(1));
        end
        // occasionally corrupt a byte
        if ($urandom_range(5) == 0)
          file_bytes[$urandom_range(file_bytes.size() - 1)] = $urandom_range(255);
      end else
        repeat ($urandom_range(1, 8)) file_bytes.push_back($urandom_range(255));
      n += file_bytes.size();
      send_file();
      if ($urandom_range(9) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    done = 1;
    if (board.failures == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/pbpl_pkg.sv
src/pbpl_parser.sv
src/pbpl_queue.sv
src/protobuf_piece_list_parser_unit.sv
test/protobuf_piece_list_parser_unit_test.sv
